FILE: hw/rtl/sha256_stream_hasher_defines.svh
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising edge outside reset
`define SHA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 assertion failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 assertion failed");
`else
`define SHA_ASSERT(lbl, ante, cons)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/sha256_pkg.sv
package sha256_pkg;

  // source of the byte shifted into the block register
  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      load;
    logic      round;
    logic [5:0] rnd;
    logic      update;
    logic      restart;
    logic [2:0] widx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } st_t;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: hw/rtl/sha256_stream_hasher.sv
// sha-256 over a byte stream: message bytes are taken while the block is idle
// a full 64-byte block then runs load, 64 rounds and hash update, no input taken
// input bytes are held off while a block is compressed, so intake and the round loop never overlap
// end of message: pad bytes, one or two compressions, then 8 digest words
// reset: hash words to the initial values, fill and bit count cleared, no clearing pass
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  // digest word stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  cmd_t cmd;
  st_t  st;

  // sequencer: byte intake, padding, round count, digest readout
  sha256_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_byte_valid (s_axis_tuser),
    .in_eom        (s_axis_tlast),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_index     (m_axis_tuser),
    .out_last      (m_axis_tlast),
    .cmd           (cmd),
    .st            (st)
  );

  // block shift register doubles as the schedule window, one round per cycle
  sha256_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .digest    (m_axis_tdata)
  );

  // intake and readout never overlap
  `SHA_ASSERT(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  // after the final digest word the block is ready for a new message
  `SHA_ASSERT_NEXT(a_back_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
  // the block register is never loaded with a byte in the middle of a round
  `SHA_ASSERT(a_push_round, cmd.push, !cmd.round && !cmd.load && !cmd.update)

endmodule

FILE: hw/rtl/sha256_dp.sv
module sha256_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  sha256_pkg::cmd_t  cmd,
  output sha256_pkg::st_t   st,
  output logic [31:0]       digest
);
  import sha256_pkg::*;

  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [511:0] blk;          // oldest schedule word in the top bits
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [63:0]  len_shift;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];

  // next schedule word from the sliding window
  assign w_new = w0 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
               + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[cmd.rnd] + w0;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // length bytes go out big-endian at positions 56 to 63
  assign len_shift = bit_count << {fill[2:0], 3'b000};

  always_comb begin
    case (cmd.sel)
      SEL_MSG: byte_in = data_byte;
      SEL_PAD: byte_in = PAD_BYTE;
      SEL_LEN: byte_in = len_shift[63:56];
      default: byte_in = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h         <= H_INIT;
      fill      <= '0;
      bit_count <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.sel == SEL_MSG) begin
          bit_count <= bit_count + 64'd8;
        end
      end
      if (cmd.update) begin
        for (int j = 0; j < 8; j++) begin
          h[j] <= h[j] + v[j];
        end
      end
      if (cmd.restart) begin
        h         <= H_INIT;
        fill      <= '0;
        bit_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.load) begin
      v <= h;
    end else if (cmd.round) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  assign st.fill = fill;
  assign digest  = h[cmd.widx];

endmodule

FILE: hw/rtl/sha256_ctrl.sv
module sha256_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_byte_valid,
  input  logic              in_eom,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_index,
  output logic              out_last,
  output sha256_pkg::cmd_t  cmd,
  input  sha256_pkg::st_t   st
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_UPD   = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       fin, fin_next;       // message is being finished
  logic       first, first_next;   // 0x80 still to go
  logic       lenph, lenph_next;   // current block carries the length

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    widx_next  = widx;
    fin_next   = fin;
    first_next = first;
    lenph_next = lenph;
    cmd        = '0;
    cmd.rnd    = rnd;
    cmd.widx   = widx;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        // no byte is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_byte_valid) begin
            cmd.push = 1'b1;
            cmd.sel  = SEL_MSG;
          end
          if (in_eom) begin
            fin_next   = 1'b1;
            first_next = 1'b1;
            lenph_next = 1'b0;
          end
          if (in_byte_valid && st.fill == FILL_LAST) begin
            state_next = S_LOAD;
          end else if (in_eom) begin
            state_next = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == ROUND_LAST) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (!fin) begin
          state_next = S_IDLE;
        end else if (first) begin
          state_next = S_PAD;
        end else if (lenph) begin
          state_next = S_OUT;
        end else begin
          lenph_next = 1'b1;
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (first) begin
          cmd.sel    = SEL_PAD;
          first_next = 1'b0;
          if (st.fill < LEN_POS) begin
            lenph_next = 1'b1;
          end
        end else if (lenph && st.fill >= LEN_POS) begin
          cmd.sel = SEL_LEN;
        end else begin
          cmd.sel = SEL_ZERO;
        end
        if (st.fill == FILL_LAST) begin
          state_next = S_LOAD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == WORD_LAST) begin
            cmd.restart = 1'b1;
            fin_next    = 1'b0;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
      widx  <= '0;
      fin   <= 1'b0;
      first <= 1'b0;
      lenph <= 1'b0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      widx  <= widx_next;
      fin   <= fin_next;
      first <= first_next;
      lenph <= lenph_next;
    end
  end

  assign out_index = widx;
  assign out_last  = (widx == WORD_LAST);

endmodule
